### src/pce_pkg.sv
// Shared types, codes and bit-manipulation functions for the programmable CRC engine.
// Used by pce_ctrl, pce_datapath and programmable_crc_engine; depends on nothing.

package pce_pkg;

    // Data path width and shifts used to left-align short writes.
    localparam int unsigned CRC_W      = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BYTE_ALIGN = 24;
    localparam int unsigned HALF_ALIGN = 16;

    // Input item kinds.
    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Write sizes.
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_NONE = 2'd3;

    // Polynomial size codes.
    localparam logic [1:0] PS_32 = 2'd0;
    localparam logic [1:0] PS_16 = 2'd1;
    localparam logic [1:0] PS_8  = 2'd2;
    localparam logic [1:0] PS_7  = 2'd3;

    // Input reversal codes.
    localparam logic [1:0] REV_NONE = 2'd0;
    localparam logic [1:0] REV_BYTE = 2'd1;
    localparam logic [1:0] REV_HALF = 2'd2;
    localparam logic [1:0] REV_WORD = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IN_REVERSE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_REVERSE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_INVERT  = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // take the input item: restart the CRC or fold a write's first byte, if any
        logic fold;   // fold the next buffered byte
        logic post;   // place the result into the output register
    } pce_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_load;  // the item being loaded needs no further byte
        logic last_fold;  // the byte being folded is the last of its write
        logic out_free;   // the output register can take a result this cycle
    } pce_stat_t;

    // Mask of the active polynomial bits.
    function automatic logic [CRC_W-1:0] size_mask(input logic [1:0] ps);
        logic [CRC_W-1:0] m;
        unique case (ps)
            PS_32:   m = 32'hFFFF_FFFF;
            PS_16:   m = 32'h0000_FFFF;
            PS_8:    m = 32'h0000_00FF;
            default: m = 32'h0000_007F;
        endcase
        return m;
    endfunction

    // Most significant active bit of the CRC for the given size.
    function automatic logic top_bit(input logic [CRC_W-1:0] c, input logic [1:0] ps);
        logic b;
        unique case (ps)
            PS_32:   b = c[31];
            PS_16:   b = c[15];
            PS_8:    b = c[7];
            default: b = c[6];
        endcase
        return b;
    endfunction

    // Eight LFSR steps, data bits taken most significant first.
    function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] c_in,
                                                   input logic [BYTE_W-1:0] d,
                                                   input logic [CRC_W-1:0] p,
                                                   input logic [1:0] ps);
        logic [CRC_W-1:0] c;
        logic [CRC_W-1:0] m;
        logic             fb;
        c = c_in;
        m = size_mask(ps);
        for (int i = 0; i < BYTE_W; i++) begin
            fb = top_bit(c, ps) ^ d[BYTE_W-1-i];
            c  = (c << 1) & m;
            if (fb)
                c = c ^ p;
        end
        return c;
    endfunction

    // Bit reversal within each byte, halfword or the whole word.
    function automatic logic [CRC_W-1:0] rev_chunks(input logic [CRC_W-1:0] x,
                                                    input logic [1:0] unit);
        logic [CRC_W-1:0] r;
        r = x;
        unique case (unit)
            REV_BYTE: begin
                for (int i = 0; i < CRC_W; i++)
                    r[(i / 8) * 8 + 7 - (i % 8)] = x[i];
            end
            REV_HALF: begin
                for (int i = 0; i < CRC_W; i++)
                    r[(i / 16) * 16 + 15 - (i % 16)] = x[i];
            end
            REV_WORD: begin
                for (int i = 0; i < CRC_W; i++)
                    r[CRC_W-1-i] = x[i];
            end
            default: r = x;
        endcase
        return r;
    endfunction

    // Reversal of the result within the polynomial size; input is already masked.
    function automatic logic [CRC_W-1:0] rev_poly(input logic [CRC_W-1:0] x,
                                                  input logic [1:0] ps);
        logic [CRC_W-1:0] r;
        r = '0;
        unique case (ps)
            PS_32: begin
                for (int i = 0; i < 32; i++)
                    r[31-i] = x[i];
            end
            PS_16: begin
                for (int i = 0; i < 16; i++)
                    r[15-i] = x[i];
            end
            PS_8: begin
                for (int i = 0; i < 8; i++)
                    r[7-i] = x[i];
            end
            default: begin
                for (int i = 0; i < 7; i++)
                    r[6-i] = x[i];
            end
        endcase
        return r;
    endfunction

endpackage

### src/pce_ctrl.sv
// Controller state machine of the programmable CRC engine.
// Depends on pce_pkg for the command and status structs.

module pce_ctrl
    import pce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  pce_stat_t stat,
    output pce_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Items wait while a write is folded or a result is held.
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!stat.last_load)
                        state_next = ST_BUSY;
                    else if (stat.out_free)
                        cmd.post = 1'b1;
                    else
                        state_next = ST_HOLD;
                end
            end
            ST_BUSY:
            begin
                cmd.fold = 1'b1;
                if (stat.last_fold)
                begin
                    if (stat.out_free)
                    begin
                        cmd.post   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (stat.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### src/pce_datapath.sv
// Datapath of the programmable CRC engine: configuration registers, byte folder,
// CRC register and output register. Depends on pce_pkg.

module pce_datapath
    import pce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CRC_W-1:0]     cfg_data,
    input  logic                 kind,
    input  logic [CRC_W-1:0]     data,
    input  logic [1:0]           size,
    input  pce_cmd_t             cmd,
    output pce_stat_t            stat,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [CRC_W-1:0]     crc_value
);

    logic [CRC_W-1:0] init_value_reg;
    logic [CRC_W-1:0] poly_reg;
    logic [1:0]       poly_size_reg;
    logic [1:0]       in_reverse_reg;
    logic             out_reverse_reg;
    logic             out_invert_reg;

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] shift_reg;
    logic [CRC_W-1:0] shift_next;
    logic [1:0]       left_reg;
    logic [1:0]       left_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CRC_W-1:0] out_value_reg;
    logic [CRC_W-1:0] out_value_next;

    logic [CRC_W-1:0] mask;
    logic [CRC_W-1:0] wdata;
    logic [CRC_W-1:0] rdata;
    logic [CRC_W-1:0] aligned;
    logic [1:0]       rev_unit;
    logic [BYTE_W-1:0] byte_in;
    logic             do_fold;
    logic [CRC_W-1:0] res;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_value_reg  <= 32'hFFFF_FFFF;
            poly_reg        <= 32'h04C1_1DB7;
            poly_size_reg   <= PS_32;
            in_reverse_reg  <= REV_NONE;
            out_reverse_reg <= 1'b0;
            out_invert_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_INIT_VALUE:  init_value_reg  <= cfg_data;
                REG_POLY:        poly_reg        <= cfg_data;
                REG_POLY_SIZE:   poly_size_reg   <= cfg_data[1:0];
                REG_IN_REVERSE:  in_reverse_reg  <= cfg_data[1:0];
                REG_OUT_REVERSE: out_reverse_reg <= cfg_data[0];
                REG_OUT_INVERT:  out_invert_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign mask = size_mask(poly_size_reg);

    // Input preparation: mask to write width, clip the reversal unit to it, left-align.
    always_comb
    begin
        unique case (size)
            SZ_BYTE: wdata = {24'd0, data[7:0]};
            SZ_HALF: wdata = {16'd0, data[15:0]};
            default: wdata = data;
        endcase
        if (in_reverse_reg == REV_NONE)
            rev_unit = REV_NONE;
        else if (size == SZ_BYTE)
            rev_unit = REV_BYTE;
        else if (size == SZ_HALF && in_reverse_reg == REV_WORD)
            rev_unit = REV_HALF;
        else
            rev_unit = in_reverse_reg;
        rdata = rev_chunks(wdata, rev_unit);
        unique case (size)
            SZ_BYTE: aligned = rdata << BYTE_ALIGN;
            SZ_HALF: aligned = rdata << HALF_ALIGN;
            default: aligned = rdata;
        endcase
    end

    // Status toward the controller.
    assign stat.last_load = (kind == KIND_RESTART) || (size == SZ_BYTE) || (size == SZ_NONE);
    assign stat.last_fold = (left_reg == 2'd1);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // Byte folder and CRC update.
    always_comb
    begin
        crc_next   = crc_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        byte_in    = shift_reg[CRC_W-1 -: BYTE_W];
        do_fold    = 1'b0;
        if (cmd.load)
        begin
            byte_in    = aligned[CRC_W-1 -: BYTE_W];
            shift_next = aligned << BYTE_W;
            if (kind == KIND_RESTART)
                crc_next = init_value_reg & mask;
            else if (size != SZ_NONE)
                do_fold = 1'b1;
            unique case (size)
                SZ_HALF: left_next = 2'd1;
                SZ_WORD: left_next = 2'd3;
                default: left_next = 2'd0;
            endcase
        end
        else if (cmd.fold)
        begin
            shift_next = shift_reg << BYTE_W;
            left_next  = left_reg - 2'd1;
            do_fold    = 1'b1;
        end
        if (do_fold)
            crc_next = fold_byte(crc_reg & mask, byte_in, poly_reg & mask, poly_size_reg);
    end

    // Output transforms on the updated CRC.
    always_comb
    begin
        res = crc_next & mask;
        if (out_reverse_reg)
            res = rev_poly(res, poly_size_reg);
        if (out_invert_reg)
            res = ~res & mask;
        out_value_next = res;
        if (cmd.post)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and CRC state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= 32'hFFFF_FFFF;
            left_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        if (cmd.post)
            out_value_reg <= out_value_next;
    end

    assign out_valid = out_valid_reg;
    assign crc_value = out_value_reg;

endmodule

### src/programmable_crc_engine.sv
// Programmable CRC engine: one byte of a write is folded into the CRC per cycle.
// The input is stalled while the later bytes of a halfword or word write are folded and while
// a result waits for the output register, so a new item is taken only after the last is posted.
// A finished result waits in the output register while the next item is taken.
// Reset is asynchronous, active low: CRC all ones, configuration registers to their defaults.
// Top level; depends on pce_pkg, pce_ctrl and pce_datapath.

module programmable_crc_engine
    import pce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CRC_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [CRC_W-1:0]     data,
    input  logic [1:0]           size,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CRC_W-1:0]     crc_value
);

    pce_cmd_t  cmd;
    pce_stat_t stat;

    // Sequencing of items.
    pce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Configuration, CRC folding and output register.
    pce_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .kind      (kind),
        .data      (data),
        .size      (size),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .crc_value (crc_value)
    );

    // A word write keeps the input stalled while its other three bytes are folded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == KIND_WRITE && size == SZ_WORD)
            |=> in_stall ##1 in_stall ##1 in_stall)
        else $error("word write did not occupy the folder for three more cycles");

    // A restart with a free output register shows its result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == KIND_RESTART && (!out_valid || !out_stall))
            |=> (out_valid && !in_stall))
        else $error("restart result not posted at once");

    // A byte write with a free output register leaves the block ready again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == KIND_WRITE && size == SZ_BYTE
            && (!out_valid || !out_stall))
            |=> (out_valid && !in_stall))
        else $error("byte write did not finish in one cycle");

    // A fold command never occurs together with taking a new item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.fold))
        else $error("load and fold issued together");

endmodule
